// ----- hdl/kch_pkg.sv -----
// Shared constants, types and helper functions of the k-mer count histogram.
package kch_pkg;

  // Word length of a k-mer and size of the symbol alphabet.
  localparam int KMER_LEN      = 3;
  localparam int ALPHABET_SIZE = 20;

  // Integer power, evaluated at elaboration only.
  function automatic int ipow(input int base, input int exp);
    int acc;
    acc = 1;
    for (int i = 0; i < exp; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Table sizes derived from the k-mer length and the alphabet.
  localparam int PREFIX_SPACE = ipow(ALPHABET_SIZE, KMER_LEN - 1);
  localparam int SLIDE_MOD    = ipow(ALPHABET_SIZE, KMER_LEN - 2);
  localparam int KMER_SPACE   = PREFIX_SPACE * ALPHABET_SIZE;

  // Field widths of the transaction payloads.
  localparam int SYM_W  = 5;
  localparam int SEL_W  = 2;
  localparam int RADR_W = 13;
  localparam int CNT_W  = 32;

  // Internal widths.
  localparam int KA_W  = $clog2(KMER_SPACE);
  localparam int WIN_W = $clog2(PREFIX_SPACE);
  localparam int POS_W = $clog2(KMER_LEN);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Read targets selected by table_select.
  localparam logic [SEL_W-1:0] TSEL_KMER   = 2'd0;
  localparam logic [SEL_W-1:0] TSEL_PREFIX = 2'd1;
  localparam logic [SEL_W-1:0] TSEL_SYMBOL = 2'd2;
  localparam logic [SEL_W-1:0] TSEL_TOTALS = 2'd3;

  // Addresses of the totals.
  localparam logic [RADR_W-1:0] TOT_KMER   = 13'd0;
  localparam logic [RADR_W-1:0] TOT_SYMBOL = 13'd1;
  localparam logic [RADR_W-1:0] TOT_RECORD = 13'd2;

  // Operation sent to a counter bank.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_INC
  } cnt_op_e;

  typedef struct packed {
    cnt_op_e           op;
    logic [KA_W-1:0]   addr;
  } cnt_req_t;

  typedef struct packed {
    logic              ready;
    logic [CNT_W-1:0]  value;
  } cnt_rsp_t;

  // Saturating increment of a counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

// ----- hdl/kch_cnt_bank.sv -----
// Counter bank: one synchronous memory with read-modify-write, forwarding and clear sweep.
module kch_cnt_bank
  import kch_pkg::*;
#(
  parameter int Depth = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  cnt_req_t req_i,
  output cnt_rsp_t rsp_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [CNT_W-1:0] mem [Depth];
  logic [CNT_W-1:0] rdata_q;

  // Second stage of the read-modify-write.
  cnt_op_e          s1_op_q;
  logic [AW-1:0]    s1_addr_q;

  // Last increment written, for a read issued in the same cycle as that write.
  logic             fwd_valid_q;
  logic [AW-1:0]    fwd_addr_q;
  logic [CNT_W-1:0] fwd_data_q;

  // Clear sweep after reset.
  logic [AW-1:0]    clr_cnt_q;
  logic             clr_done_q;

  logic [CNT_W-1:0] cur_value;
  logic [CNT_W-1:0] inc_value;
  logic             upd_en;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] wr_data;

  // Current value of the entry in the second stage, with forwarding.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr_q)) begin
      cur_value = fwd_data_q;
    end else begin
      cur_value = rdata_q;
    end
    inc_value = sat_inc(cur_value);
    upd_en    = en_i && (s1_op_q == OP_INC);
    if (!clr_done_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else begin
      wr_en   = upd_en;
      wr_addr = s1_addr_q;
      wr_data = inc_value;
    end
  end

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en_i) begin
      rdata_q <= mem[req_i.addr[AW-1:0]];
    end
  end

  // Pipeline, forwarding and clear control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_op_q     <= OP_NONE;
      s1_addr_q   <= '0;
      fwd_valid_q <= 1'b0;
      fwd_addr_q  <= '0;
      fwd_data_q  <= '0;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
    end else begin
      if (!clr_done_q) begin
        if (clr_cnt_q == AW'(Depth - 1)) begin
          clr_done_q <= 1'b1;
        end else begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
        end
      end
      if (en_i) begin
        s1_op_q   <= req_i.op;
        s1_addr_q <= req_i.addr[AW-1:0];
      end
      if (upd_en) begin
        fwd_valid_q <= 1'b1;
        fwd_addr_q  <= s1_addr_q;
        fwd_data_q  <= inc_value;
      end
    end
  end

  assign rsp_o.ready = clr_done_q;
  assign rsp_o.value = cur_value;

endmodule

// ----- hdl/kmer_count_histogram_top.sv -----
// A read transaction gives its count after it passes the second stage and the output register.
// Throughput: one transaction per cycle, feed or read, while stall_o is low, limited by the one
// read-modify-write per cycle on each counter memory.
// Reset: the window and the totals clear; all three counter memories are then swept to
// zero, during which stall_o stays high.
module kmer_count_histogram_top
  import kch_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic              action_i,
  input  logic              record_start_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic [SEL_W-1:0]  table_select_i,
  input  logic [RADR_W-1:0] read_address_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [CNT_W-1:0]  count_value_o
);

  // Window state and totals.
  logic [WIN_W-1:0] window_q;
  logic [POS_W-1:0] pos_q;
  logic [SYM_W-1:0] hist_q [KMER_LEN-1];
  logic [CNT_W-1:0] kmer_total_q;
  logic [CNT_W-1:0] symbol_total_q;
  logic [CNT_W-1:0] record_total_q;

  // Second stage and output register.
  logic             s1_rd_q;
  logic [SEL_W-1:0] s1_sel_q;
  logic             s1_inrange_q;
  logic [CNT_W-1:0] s1_total_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] count_q;

  logic             advance;
  logic             ready;
  logic             accept;
  logic             feed;
  logic             rd;
  logic [POS_W-1:0] pos_eff;
  logic [WIN_W-1:0] win_eff;
  logic             in_prefix;
  logic [POS_W-1:0] new_pos;
  logic [KA_W-1:0]  ext_idx;
  logic [WIN_W-1:0] slide_rem;
  logic [WIN_W-1:0] slide_idx;
  logic             rd_inrange;
  logic [CNT_W-1:0] rd_total;
  logic [CNT_W-1:0] s1_result;

  cnt_req_t kmer_req, prefix_req, symbol_req;
  cnt_rsp_t kmer_rsp, prefix_rsp, symbol_rsp;

  // Handshake: the pipeline moves unless a finished count is held by the sink.
  assign advance = !(out_valid_q && stall_i);
  assign ready   = kmer_rsp.ready && prefix_rsp.ready && symbol_rsp.ready;
  assign stall_o = !(advance && ready);
  assign accept  = valid_i && !stall_o;
  assign feed    = accept && !action_i && (32'(symbol_i) < 32'(ALPHABET_SIZE));
  assign rd      = accept && action_i;

  // Window arithmetic for the incoming symbol.
  always_comb begin
    pos_eff   = record_start_i ? '0 : pos_q;
    win_eff   = record_start_i ? '0 : window_q;
    in_prefix = pos_eff < POS_W'(KMER_LEN - 1);
    new_pos   = pos_eff + POS_W'(1);
    ext_idx   = KA_W'(KA_W'(win_eff) * KA_W'(ALPHABET_SIZE) + KA_W'(symbol_i));
    slide_rem = WIN_W'(window_q
                - WIN_W'(WIN_W'(hist_q[KMER_LEN-2]) * WIN_W'(SLIDE_MOD)));
    slide_idx = WIN_W'(KA_W'(slide_rem) * KA_W'(ALPHABET_SIZE) + KA_W'(symbol_i));
  end

  // Range check and totals selection of a read.
  always_comb begin
    rd_total = '0;
    case (table_select_i)
      TSEL_KMER:   rd_inrange = 32'(read_address_i) < 32'(KMER_SPACE);
      TSEL_PREFIX: rd_inrange = 32'(read_address_i) < 32'(PREFIX_SPACE);
      TSEL_SYMBOL: rd_inrange = 32'(read_address_i) < 32'(ALPHABET_SIZE);
      default: begin
        rd_inrange = 1'b1;
        if (read_address_i == TOT_KMER) begin
          rd_total = kmer_total_q;
        end else if (read_address_i == TOT_SYMBOL) begin
          rd_total = symbol_total_q;
        end else if (read_address_i == TOT_RECORD) begin
          rd_total = record_total_q;
        end
      end
    endcase
  end

  // Requests to the counter banks.
  always_comb begin
    kmer_req.op     = OP_NONE;
    kmer_req.addr   = KA_W'(read_address_i);
    prefix_req.op   = OP_NONE;
    prefix_req.addr = KA_W'(read_address_i);
    symbol_req.op   = OP_NONE;
    symbol_req.addr = KA_W'(read_address_i);
    if (feed) begin
      symbol_req.op   = OP_INC;
      symbol_req.addr = KA_W'(symbol_i);
      if (in_prefix) begin
        prefix_req.addr = ext_idx;
        if (new_pos == POS_W'(KMER_LEN - 1)) begin
          prefix_req.op = OP_INC;
        end
      end else begin
        kmer_req.op     = OP_INC;
        kmer_req.addr   = ext_idx;
        prefix_req.op   = OP_INC;
        prefix_req.addr = KA_W'(slide_idx);
      end
    end else if (rd && rd_inrange) begin
      if (table_select_i == TSEL_KMER) begin
        kmer_req.op = OP_READ;
      end
      if (table_select_i == TSEL_PREFIX) begin
        prefix_req.op = OP_READ;
      end
      if (table_select_i == TSEL_SYMBOL) begin
        symbol_req.op = OP_READ;
      end
    end
  end

  kch_cnt_bank #(.Depth(KMER_SPACE)) u_kmer_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (kmer_req),
    .rsp_o  (kmer_rsp)
  );

  kch_cnt_bank #(.Depth(PREFIX_SPACE)) u_prefix_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (prefix_req),
    .rsp_o  (prefix_rsp)
  );

  kch_cnt_bank #(.Depth(ALPHABET_SIZE)) u_symbol_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (symbol_req),
    .rsp_o  (symbol_rsp)
  );

  // Count returned by the read in the second stage.
  always_comb begin
    s1_result = '0;
    if (s1_inrange_q) begin
      case (s1_sel_q)
        TSEL_KMER:   s1_result = kmer_rsp.value;
        TSEL_PREFIX: s1_result = prefix_rsp.value;
        TSEL_SYMBOL: s1_result = symbol_rsp.value;
        default:     s1_result = s1_total_q;
      endcase
    end
  end

  // Window, totals, second stage and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q       <= '0;
      pos_q          <= '0;
      for (int i = 0; i < KMER_LEN - 1; i++) begin
        hist_q[i] <= '0;
      end
      kmer_total_q   <= '0;
      symbol_total_q <= '0;
      record_total_q <= '0;
      s1_rd_q        <= 1'b0;
      s1_sel_q       <= '0;
      s1_inrange_q   <= 1'b0;
      s1_total_q     <= '0;
      out_valid_q    <= 1'b0;
      count_q        <= '0;
    end else begin
      if (feed) begin
        symbol_total_q <= sat_inc(symbol_total_q);
        if (record_start_i) begin
          record_total_q <= sat_inc(record_total_q);
        end
        hist_q[0] <= symbol_i;
        for (int i = 1; i < KMER_LEN - 1; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
        if (in_prefix) begin
          window_q <= WIN_W'(ext_idx);
          pos_q    <= new_pos;
        end else begin
          window_q     <= slide_idx;
          pos_q        <= pos_eff;
          kmer_total_q <= sat_inc(kmer_total_q);
        end
      end
      if (advance) begin
        s1_rd_q      <= rd;
        s1_sel_q     <= table_select_i;
        s1_inrange_q <= rd_inrange;
        s1_total_q   <= rd_total;
        out_valid_q  <= s1_rd_q;
        if (s1_rd_q) begin
          count_q <= s1_result;
        end
      end
    end
  end

  assign valid_o       = out_valid_q;
  assign count_value_o = count_q;

endmodule

// ----- hdl/kch_checker.sv -----
// Port-level checker of the k-mer count histogram and its bind to the top level.
module kch_checker
  import kch_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_i,
  input logic             stall_o,
  input logic             action_i,
  input logic             valid_o,
  input logic             stall_i,
  input logic [CNT_W-1:0] count_value_o
);

  // A result held by the sink stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result transaction dropped while stalled");

  // Its count stays unchanged while stalled.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(count_value_o))
    else $error("result count changed while stalled");

  // Right after reset the counter memories are being cleared.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> stall_o)
    else $error("input accepted during the clear sweep");

  // A read reaches the output through the second stage and the output register when the output is free.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && action_i ##1 !valid_o |=> valid_o)
    else $error("read transaction gave no result");

  // A feed never produces a result.
  a_feed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && !action_i ##1 !valid_o |=> !valid_o)
    else $error("feed transaction produced a result");

endmodule

bind kmer_count_histogram_top kch_checker u_kch_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (valid_i),
  .stall_o       (stall_o),
  .action_i      (action_i),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .count_value_o (count_value_o)
);
